@@ src/nlrf_pkg.sv @@
// nlrf_pkg: shared types, ASCII codes and decimal helper functions for the
// node list range formatter. No dependencies.
`default_nettype none

package nlrf_pkg;

	localparam int NODE_BITS_DEF  = 16;  // default node number width
	localparam int IN_DATA_BITS   = 16;  // width of node_number on the port
	localparam int CHAR_BITS      = 8;
	localparam int QUEUE_DEPTH    = 4;   // command queue between front and back
	localparam int POW_BITS       = 34;  // holds 10^10 > 2^32
	localparam int POS_ARG_BITS   = 4;   // digit position argument, 0..9

	localparam logic [CHAR_BITS-1:0] CH_ZERO  = 8'h30;  // '0'
	localparam logic [CHAR_BITS-1:0] CH_DOT   = 8'h2E;  // '.'
	localparam logic [CHAR_BITS-1:0] CH_COMMA = 8'h2C;  // ','

	// run direction codes
	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_UP   = 2'd1;
	localparam logic [1:0] DIR_DOWN = 2'd2;

	// what one command asks the back end to print, in this order:
	// "..run", ",", "num"; last puts the end mark on the final character
	typedef struct packed {
		logic has_run;
		logic has_comma;
		logic has_num;
		logic last;
	} cmd_flags_t;

	// 10^p as a constant table
	function automatic logic [POW_BITS-1:0] pow10(input logic [POS_ARG_BITS-1:0] p);
		logic [POW_BITS-1:0] r;
		unique case (p)
			4'd0:    r = 34'd1;
			4'd1:    r = 34'd10;
			4'd2:    r = 34'd100;
			4'd3:    r = 34'd1000;
			4'd4:    r = 34'd10000;
			4'd5:    r = 34'd100000;
			4'd6:    r = 34'd1000000;
			4'd7:    r = 34'd10000000;
			4'd8:    r = 34'd100000000;
			4'd9:    r = 34'd1000000000;
			default: r = 34'd0;
		endcase
		return r;
	endfunction

	// position of the leading decimal digit (digit count minus one)
	function automatic logic [POS_ARG_BITS-1:0] lead_pos(input logic [31:0] v);
		logic [POS_ARG_BITS-1:0] r;
		logic [POW_BITS-1:0]     v_ext;
		r     = '0;
		v_ext = POW_BITS'(v);
		for (int p = 1; p < 10; p++) begin
			if (v_ext >= pow10(POS_ARG_BITS'(p)))
				r = POS_ARG_BITS'(p);
		end
		return r;
	endfunction

	// leading digit position of the largest value of a given width
	function automatic int max_pos(input int bits);
		logic [63:0] m;
		m = (64'd1 << bits) - 64'd1;
		return int'(lead_pos(m[31:0]));
	endfunction

endpackage

`default_nettype wire

@@ src/node_list_range_formatter_top.sv @@
// node_list_range_formatter_top: top level of the node list range formatter.
// Depends on nlrf_pkg, nlrf_front, nlrf_queue and nlrf_back.
`default_nettype none

// Takes node numbers one per transaction (tlast marks the final number of a
// list) and streams the list as ASCII text in range form, one character per
// output transaction: runs of consecutive numbers, rising or falling, print
// as "first..last", groups are separated by ",", numbers are unsigned decimal
// without leading zeros, and tlast marks the final character of the list.
// Only the low NODE_BITS bits of a node number are used. The front end
// classifies each number combinationally and can take one per cycle while
// its four-entry command queue has room; a number that only extends a run
// prints nothing. The back end prints one character per cycle while the
// output is not stalled, so an item produces one to thirteen characters
// at 16-bit node numbers ("..", five digits, ",", five digits).
// Output is registered, and a stalled output does not block input until
// the queue fills.
module node_list_range_formatter_top import nlrf_pkg::*; #(
	parameter int NODE_BITS = NODE_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    s_tvalid,
	output logic                         s_tready,
	input  wire logic [IN_DATA_BITS-1:0] s_tdata,   // [15:0] node_number
	input  wire logic                    s_tlast,   // is_last
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [CHAR_BITS-1:0]         m_tdata,   // [7:0] out_char
	output logic                         m_tlast    // end_of_text
);

	// digit position counter width, from the largest printable number
	localparam int POS_W  = $clog2(max_pos(NODE_BITS) + 1);
	localparam int FLAG_W = $bits(cmd_flags_t);
	localparam int CMD_W  = FLAG_W + 2 * (NODE_BITS + POS_W);

	// front end command
	logic                 f_valid, f_ready;
	cmd_flags_t           f_flags;
	logic [NODE_BITS-1:0] f_run_val, f_num_val;
	logic [POS_W-1:0]     f_run_pos, f_num_pos;

	// queue head toward the back end
	logic                 b_valid, b_ready;
	cmd_flags_t           b_flags;
	logic [NODE_BITS-1:0] b_run_val, b_num_val;
	logic [POS_W-1:0]     b_run_pos, b_num_pos;

	logic [CMD_W-1:0]     q_wr_data, q_rd_data;

	nlrf_front #(
		.NODE_BITS (NODE_BITS),
		.POS_W     (POS_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_node     (s_tdata),
		.in_last     (s_tlast),
		.cmd_valid   (f_valid),
		.cmd_ready   (f_ready),
		.cmd_flags   (f_flags),
		.cmd_run_val (f_run_val),
		.cmd_run_pos (f_run_pos),
		.cmd_num_val (f_num_val),
		.cmd_num_pos (f_num_pos)
	);

	assign q_wr_data = {f_flags, f_run_val, f_run_pos, f_num_val, f_num_pos};

	nlrf_queue #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (q_wr_data),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (q_rd_data)
	);

	assign {b_flags, b_run_val, b_run_pos, b_num_val, b_num_pos} = q_rd_data;

	nlrf_back #(
		.NODE_BITS (NODE_BITS),
		.POS_W     (POS_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (b_valid),
		.cmd_ready   (b_ready),
		.cmd_flags   (b_flags),
		.cmd_run_val (b_run_val),
		.cmd_run_pos (b_run_pos),
		.cmd_num_val (b_num_val),
		.cmd_num_pos (b_num_pos),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_char    (m_tdata),
		.out_end     (m_tlast)
	);

endmodule

`default_nettype wire

@@ src/nlrf_front.sv @@
// nlrf_front: accepts node numbers, tracks the open group and run direction,
// and issues print commands. Depends on nlrf_pkg.
`default_nettype none

module nlrf_front import nlrf_pkg::*; #(
	parameter int NODE_BITS = NODE_BITS_DEF,
	parameter int POS_W     = 3
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [IN_DATA_BITS-1:0] in_node,
	input  wire logic                    in_last,
	output logic                         cmd_valid,
	input  wire logic                    cmd_ready,
	output cmd_flags_t                   cmd_flags,
	output logic [NODE_BITS-1:0]         cmd_run_val,
	output logic [POS_W-1:0]             cmd_run_pos,
	output logic [NODE_BITS-1:0]         cmd_num_val,
	output logic [POS_W-1:0]             cmd_num_pos
);

	logic [NODE_BITS-1:0] prev_q;
	logic [1:0]           dir_q;
	logic                 open_q;

	logic [NODE_BITS-1:0] x;
	logic                 up, down, cont, needs_cmd, accept;

	assign x    = NODE_BITS'(in_node);
	assign up   = (prev_q != '1) && (x == prev_q + NODE_BITS'(1));
	assign down = (prev_q != '0) && (x + NODE_BITS'(1) == prev_q);
	assign cont = ((dir_q == DIR_NONE) && (up || down)) ||
	              ((dir_q == DIR_UP) && up) || ((dir_q == DIR_DOWN) && down);

	// a continuing run prints nothing unless it closes the list
	assign needs_cmd = !open_q || !cont || in_last;

	assign in_ready  = cmd_ready;
	assign accept    = in_valid && in_ready;
	assign cmd_valid = in_valid && needs_cmd;

	always_comb begin
		cmd_flags   = '0;
		cmd_run_val = x;
		cmd_num_val = x;
		cmd_flags.last = in_last;
		if (!open_q) begin
			cmd_flags.has_num = 1'b1;
		end else if (cont) begin
			cmd_flags.has_run = 1'b1;
		end else begin
			cmd_flags.has_run   = (dir_q != DIR_NONE);
			cmd_run_val         = prev_q;
			cmd_flags.has_comma = 1'b1;
			cmd_flags.has_num   = 1'b1;
		end
	end

	assign cmd_run_pos = POS_W'(lead_pos(32'(cmd_run_val)));
	assign cmd_num_pos = POS_W'(lead_pos(32'(cmd_num_val)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			dir_q  <= DIR_NONE;
			open_q <= 1'b0;
		end else if (accept) begin
			if (in_last) begin
				prev_q <= '0;
				dir_q  <= DIR_NONE;
				open_q <= 1'b0;
			end else begin
				prev_q <= x;
				open_q <= 1'b1;
				if (!open_q || !cont)
					dir_q <= DIR_NONE;
				else if (dir_q == DIR_NONE)
					dir_q <= up ? DIR_UP : DIR_DOWN;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/nlrf_queue.sv @@
// nlrf_queue: small command FIFO decoupling front and back end.
// Depends on nlrf_pkg.
`default_nettype none

module nlrf_queue import nlrf_pkg::*; #(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_valid,
	output logic                  wr_ready,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  wire logic             rd_ready,
	output logic [WIDTH-1:0]      rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push, pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

`default_nettype wire

@@ src/nlrf_back.sv @@
// nlrf_back: prints a command as characters, one per cycle unless stalled,
// leading digit first, into a registered output stage. Depends on nlrf_pkg.
`default_nettype none

module nlrf_back import nlrf_pkg::*; #(
	parameter int NODE_BITS = NODE_BITS_DEF,
	parameter int POS_W     = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	input  wire cmd_flags_t           cmd_flags,
	input  wire logic [NODE_BITS-1:0] cmd_run_val,
	input  wire logic [POS_W-1:0]     cmd_run_pos,
	input  wire logic [NODE_BITS-1:0] cmd_num_val,
	input  wire logic [POS_W-1:0]     cmd_num_pos,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [CHAR_BITS-1:0]      out_char,
	output logic                      out_end
);

	localparam logic [2:0] PH_DOT1  = 3'd0;
	localparam logic [2:0] PH_DOT2  = 3'd1;
	localparam logic [2:0] PH_RUN   = 3'd2;
	localparam logic [2:0] PH_COMMA = 3'd3;
	localparam logic [2:0] PH_NUM   = 3'd4;

	logic                 cur_valid_q;
	cmd_flags_t           flags_q;
	logic [NODE_BITS-1:0] num_val_q;
	logic [POS_W-1:0]     num_pos_q;
	logic [NODE_BITS-1:0] w_q;       // value being printed
	logic [POS_W-1:0]     p_q;       // current digit position
	logic [2:0]           phase_q;

	logic                 out_valid_q, out_end_q;
	logic [CHAR_BITS-1:0] out_char_q;

	logic                 adv, emit, finish, load;
	logic [POW_BITS-1:0]  pw, w_ext, rem;
	logic [POW_BITS-1:0]  mul [10];
	logic [3:0]           dig;
	logic [CHAR_BITS-1:0] ch;
	logic [NODE_BITS-1:0] w_next;

	// one decimal digit per step: compare against the nine multiples of 10^p
	assign pw    = pow10(POS_ARG_BITS'(p_q));
	assign w_ext = POW_BITS'(w_q);
	always_comb begin
		dig = '0;
		for (int d = 0; d < 10; d++)
			mul[d] = pw * POW_BITS'(d);
		for (int d = 1; d < 10; d++) begin
			if (w_ext >= mul[d])
				dig = 4'(d);
		end
	end
	assign rem    = w_ext - mul[dig];
	assign w_next = NODE_BITS'(rem);

	always_comb begin
		unique case (phase_q)
			PH_DOT1, PH_DOT2: ch = CH_DOT;
			PH_COMMA:         ch = CH_COMMA;
			PH_RUN, PH_NUM:   ch = CH_ZERO + CHAR_BITS'(dig);
			default:          ch = CH_ZERO;
		endcase
	end

	assign adv    = !out_valid_q || out_ready;
	assign emit   = adv && cur_valid_q;
	assign finish = emit && (p_q == '0) &&
	                ((phase_q == PH_NUM) || (phase_q == PH_RUN && !flags_q.has_comma));
	assign load      = !cur_valid_q || finish;
	assign cmd_ready = load;

	always_ff @(posedge clk) begin
		if (load && cmd_valid) begin
			flags_q   <= cmd_flags;
			num_val_q <= cmd_num_val;
			num_pos_q <= cmd_num_pos;
			if (cmd_flags.has_run) begin
				w_q     <= cmd_run_val;
				p_q     <= cmd_run_pos;
				phase_q <= PH_DOT1;
			end else begin
				w_q     <= cmd_num_val;
				p_q     <= cmd_num_pos;
				phase_q <= cmd_flags.has_comma ? PH_COMMA : PH_NUM;
			end
		end else if (emit) begin
			unique case (phase_q)
				PH_DOT1:  phase_q <= PH_DOT2;
				PH_DOT2:  phase_q <= PH_RUN;
				PH_COMMA: phase_q <= PH_NUM;
				PH_RUN: begin
					if (p_q == '0) begin
						// run end done, the new number follows the comma
						w_q     <= num_val_q;
						p_q     <= num_pos_q;
						phase_q <= PH_COMMA;
					end else begin
						w_q <= w_next;
						p_q <= p_q - POS_W'(1);
					end
				end
				PH_NUM: begin
					w_q <= w_next;
					p_q <= p_q - POS_W'(1);
				end
				default: phase_q <= PH_NUM;
			endcase
		end
		if (adv && emit) begin
			out_char_q <= ch;
			out_end_q  <= finish && flags_q.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load)
				cur_valid_q <= cmd_valid;
			if (adv)
				out_valid_q <= emit;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_end   = out_end_q;

endmodule

`default_nettype wire
